// ===== hdl/fstm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fstm_pkg
// Shared types and constants for the flat span texture mapper.
// ----------------------------------------------------------------------------
package fstm_pkg;

  // Fixed field widths
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned POS_BITS   = 32;
  localparam int unsigned TEXEL_BITS = 15;
  localparam int unsigned PIXEL_BITS = 16;
  localparam int unsigned INDEX_BITS = 14;
  localparam int unsigned VALUE_BITS = 16;

  // Operation codes carried by an input item
  typedef enum logic [1:0] {
    OP_START      = 2'd0,
    OP_LOAD_TEXEL = 2'd1,
    OP_LOAD_SHADE = 2'd2,
    OP_DRAW       = 2'd3
  } op_e;

  // Memory port control
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctrl_t;

  // Span generator control
  typedef struct packed {
    logic start;
    logic advance;
  } span_ctrl_t;

endpackage : fstm_pkg
`default_nettype wire

// ===== hdl/fstm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fstm_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data and a read enable that holds the last word.
// ----------------------------------------------------------------------------
module fstm_ram #(
  parameter int unsigned DATA_W = 16,
  parameter int unsigned ADDR_W = 12
) (
  input  wire                    clk_i,
  input  fstm_pkg::ram_ctrl_t    ctrl_i,
  input  wire [ADDR_W-1:0]       waddr_i,
  input  wire [DATA_W-1:0]       wdata_i,
  input  wire [ADDR_W-1:0]       raddr_i,
  output logic [DATA_W-1:0]      rdata_o
);
  import fstm_pkg::*;

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, hold data while not enabled
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : fstm_ram
`default_nettype wire

// ===== hdl/fstm_span_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fstm_span_gen
// Holds the 16.16 u and v positions and steps, forms the texel address
// and advances the positions after each drawn pixel.
// ----------------------------------------------------------------------------
module fstm_span_gen #(
  parameter int unsigned TEX_SIDE_LOG2 = 6
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  fstm_pkg::span_ctrl_t               ctrl_i,
  input  wire [fstm_pkg::POS_BITS-1:0]       start_u_i,
  input  wire [fstm_pkg::POS_BITS-1:0]       start_v_i,
  input  wire [fstm_pkg::POS_BITS-1:0]       step_u_i,
  input  wire [fstm_pkg::POS_BITS-1:0]       step_v_i,
  output logic [2*TEX_SIDE_LOG2-1:0]         addr_o
);
  import fstm_pkg::*;

  logic [POS_BITS-1:0] u_q, u_d, v_q, v_d, du_q, du_d, dv_q, dv_d;

  // Latch a new span or step along the current one
  always_comb begin
    u_d  = u_q;
    v_d  = v_q;
    du_d = du_q;
    dv_d = dv_q;
    if (ctrl_i.start) begin
      u_d  = start_u_i;
      v_d  = start_v_i;
      du_d = step_u_i;
      dv_d = step_v_i;
    end else if (ctrl_i.advance) begin
      u_d = u_q + du_q;
      v_d = v_q + dv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q  <= '0;
      v_q  <= '0;
      du_q <= '0;
      dv_q <= '0;
    end else begin
      u_q  <= u_d;
      v_q  <= v_d;
      du_q <= du_d;
      dv_q <= dv_d;
    end
  end

  // Row from the integer part of v, column from the integer part of u
  assign addr_o = {v_q[FRAC_BITS +: TEX_SIDE_LOG2], u_q[FRAC_BITS +: TEX_SIDE_LOG2]};

endmodule : fstm_span_gen
`default_nettype wire

// ===== hdl/flat_span_texture_mapper_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted draw item gives its pixel after the texture read
// and then the shade table read, whose register is the output.
// Throughput: one item per cycle; the two memory reads are pipelined and
// the whole pipe holds while a waiting pixel is stalled.
// Reset: positions and steps clear to zero, pipeline empties; the texture
// and shade memories are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// flat_span_texture_mapper_core
// Affine span texture mapper: texture memory, shade table memory and a
// u/v stepper in a pipeline.
// ----------------------------------------------------------------------------
module flat_span_texture_mapper_core #(
  parameter int unsigned TEX_SIDE_LOG2    = 6,
  parameter int unsigned SHADE_INDEX_BITS = 14
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire [1:0]                           operation_i,
  input  wire signed [fstm_pkg::POS_BITS-1:0] start_u_i,
  input  wire signed [fstm_pkg::POS_BITS-1:0] start_v_i,
  input  wire signed [fstm_pkg::POS_BITS-1:0] step_u_i,
  input  wire signed [fstm_pkg::POS_BITS-1:0] step_v_i,
  input  wire [fstm_pkg::INDEX_BITS-1:0]      table_index_i,
  input  wire [fstm_pkg::VALUE_BITS-1:0]      table_value_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [fstm_pkg::PIXEL_BITS-1:0]     pixel_o,
  output logic [2*TEX_SIDE_LOG2-1:0]          texel_address_o
);
  import fstm_pkg::*;

  localparam int unsigned TEX_ADDR_W = 2 * TEX_SIDE_LOG2;
  localparam int unsigned SHADE_SRC  = TEXEL_BITS - 1;

  logic                  adv;
  logic                  accept;
  op_e                   op;
  ram_ctrl_t             tex_ctrl, shade_ctrl;
  span_ctrl_t            span_ctrl;
  logic [TEX_ADDR_W-1:0] span_addr;
  logic [TEX_ADDR_W-1:0] addr_s1_q, addr_s2_q;
  logic                  valid_s1_q, valid_s2_q;
  logic [TEXEL_BITS-1:0] texel;
  logic [PIXEL_BITS-1:0] pixel;

  logic [INDEX_BITS+TEX_ADDR_W-1:0]       tex_waddr_ext;
  logic [INDEX_BITS+SHADE_INDEX_BITS-1:0] shade_waddr_ext;
  logic [SHADE_SRC+SHADE_INDEX_BITS-1:0]  shade_raddr_ext;

  // Advance the whole pipe unless a finished pixel is held
  assign adv        = !(valid_s2_q && out_stall_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;
  assign op         = op_e'(operation_i);

  // Decode the accepted item
  always_comb begin
    tex_ctrl          = '0;
    shade_ctrl        = '0;
    span_ctrl         = '0;
    tex_ctrl.rd_en    = accept && (op == OP_DRAW);
    shade_ctrl.rd_en  = adv && valid_s1_q;
    span_ctrl.advance = accept && (op == OP_DRAW);
    if (accept) begin
      unique case (op)
        OP_START:      span_ctrl.start  = 1'b1;
        OP_LOAD_TEXEL: tex_ctrl.wr_en   = 1'b1;
        OP_LOAD_SHADE: shade_ctrl.wr_en = 1'b1;
        OP_DRAW:       ;
        default:       ;
      endcase
    end
  end

  // Wrap or zero-extend load indexes to the memory sizes
  assign tex_waddr_ext   = {{TEX_ADDR_W{1'b0}}, table_index_i};
  assign shade_waddr_ext = {{SHADE_INDEX_BITS{1'b0}}, table_index_i};
  // Shade index is texel shifted right by one, fitted to the table
  assign shade_raddr_ext = {{SHADE_INDEX_BITS{1'b0}}, texel[TEXEL_BITS-1:1]};

  fstm_span_gen #(
    .TEX_SIDE_LOG2(TEX_SIDE_LOG2)
  ) u_span_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (span_ctrl),
    .start_u_i (start_u_i),
    .start_v_i (start_v_i),
    .step_u_i  (step_u_i),
    .step_v_i  (step_v_i),
    .addr_o    (span_addr)
  );

  // Texture memory, top bit of the loaded word dropped
  fstm_ram #(
    .DATA_W(TEXEL_BITS),
    .ADDR_W(TEX_ADDR_W)
  ) u_tex_ram (
    .clk_i   (clk_i),
    .ctrl_i  (tex_ctrl),
    .waddr_i (tex_waddr_ext[TEX_ADDR_W-1:0]),
    .wdata_i (table_value_i[TEXEL_BITS-1:0]),
    .raddr_i (span_addr),
    .rdata_o (texel)
  );

  // Shade table memory, its read register is the output pixel
  fstm_ram #(
    .DATA_W(PIXEL_BITS),
    .ADDR_W(SHADE_INDEX_BITS)
  ) u_shade_ram (
    .clk_i   (clk_i),
    .ctrl_i  (shade_ctrl),
    .waddr_i (shade_waddr_ext[SHADE_INDEX_BITS-1:0]),
    .wdata_i (table_value_i),
    .raddr_i (shade_raddr_ext[SHADE_INDEX_BITS-1:0]),
    .rdata_o (pixel)
  );

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_s1_q <= 1'b0;
      valid_s2_q <= 1'b0;
    end else if (adv) begin
      valid_s1_q <= accept && (op == OP_DRAW);
      valid_s2_q <= valid_s1_q;
    end
  end

  // Carry the texel address alongside the reads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      addr_s1_q <= span_addr;
      addr_s2_q <= addr_s1_q;
    end
  end

  assign out_valid_o     = valid_s2_q;
  assign pixel_o         = pixel;
  assign texel_address_o = addr_s2_q;

endmodule : flat_span_texture_mapper_core
`default_nettype wire

// ===== hdl/fstm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fstm_checker
// Port-level checks for the flat span texture mapper, bound to the core.
// ----------------------------------------------------------------------------
module fstm_checker #(
  parameter int unsigned TEX_SIDE_LOG2 = 6
) (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              in_valid_i,
  input wire                              in_stall_o,
  input wire [1:0]                        operation_i,
  input wire                              out_valid_o,
  input wire                              out_stall_i,
  input wire [fstm_pkg::PIXEL_BITS-1:0]   pixel_o,
  input wire [2*TEX_SIDE_LOG2-1:0]        texel_address_o
);
  import fstm_pkg::*;

  logic draw_acc;
  assign draw_acc = in_valid_i && !in_stall_o && (operation_i == OP_DRAW);

  // Hold a stalled pixel
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_o)
      && $stable(texel_address_o))
    else $error("stalled pixel changed");

  // Stall input only behind a held pixel
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held pixel");

  // A drawn item is followed by a pixel after both memory reads
  a_draw_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_acc |=> ##1 out_valid_o)
    else $error("draw item gave no pixel");

  // A new pixel comes only from a draw item
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(draw_acc, 2))
    else $error("pixel without a draw item");

endmodule : fstm_checker

bind flat_span_texture_mapper_core fstm_checker #(
  .TEX_SIDE_LOG2(TEX_SIDE_LOG2)
) u_fstm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .operation_i     (operation_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .pixel_o         (pixel_o),
  .texel_address_o (texel_address_o)
);
`default_nettype wire
